// ===== rtl/i2ctcb_pkg.sv =====
// Shared constants and types of the I2C target command buffer.
`default_nettype none
package i2ctcb_pkg;

  localparam int BUFFER_SIZE = 32;
  // address width of both stores, width of the reply pointer (0..BUFFER_SIZE)
  localparam int AW = $clog2(BUFFER_SIZE);
  localparam int IW = $clog2(BUFFER_SIZE + 1);

  localparam logic [AW-1:0] RX_LIMIT = AW'(BUFFER_SIZE - 1);
  localparam logic [IW-1:0] REPLY_END = IW'(BUFFER_SIZE);

  typedef enum logic [2:0] {
    CMD_ADDR_WRITE = 3'd0,
    CMD_DATA_BYTE  = 3'd1,
    CMD_STOP       = 3'd2,
    CMD_ADDR_READ  = 3'd3,
    CMD_DATA_ACK   = 3'd4,
    CMD_DATA_NACK  = 3'd5,
    CMD_TICK       = 3'd6
  } cmd_e;

  // command bytes recognized by the parser
  localparam logic [7:0] OP_WDOG_B0   = 8'h01;
  localparam logic [7:0] OP_WDOG_B1   = 8'h02;
  localparam logic [7:0] OP_SYS_RESET = 8'h06;
  localparam logic [7:0] OP_REPLY     = 8'h07;
  localparam logic [7:0] REPLY_BYTE   = 8'h67;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD0,
    ST_RD1,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic       acked;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       watchdog_reset_request;
    logic       system_reset_request;
    logic       listening;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/i2ctcb_ram.sv =====
// Simple dual-port RAM, one write and one registered read port.
`default_nettype none
module i2ctcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire [$clog2(DEPTH)-1:0]  waddr_i,
  input  wire [WIDTH-1:0]          wdata_i,
  input  wire                      re_i,
  input  wire [$clog2(DEPTH)-1:0]  raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/i2c_target_command_buffer.sv =====
// Top level of the I2C target command buffer: event sequencer around two stores.
`default_nettype none
// Usage
//   Slave channel (s_axis): one bus event or periodic tick per transfer.
//     tuser carries the event code, tdata the received byte and the fault bit.
//   Master channel (m_axis): exactly one result per accepted event.
//   Every event walks the same sequence: accept (ST_IDLE), read for
//   receive byte 0 and the reply byte (ST_RD0), read for receive byte 1
//   (ST_RD1), then update and result load (ST_FIN). The single read port
//   of each store and its registered read set it. The result sits in an
//   output register, so the next event is accepted in ST_IDLE while a
//   finished result still waits. A stalled receiver holds the sequencer in
//   ST_FIN only when the output register is still full.
//   Reset: listening set, counts and pointer cleared, and every entry of both
//   stores reads as zero through per-entry valid flags (no clearing pass).
//   A parse tick clears those flags as it commits, so it costs no extra time.
module i2c_target_command_buffer (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [15:0] s_axis_tdata_i,   // [7:0] data, [8] bus_fault, rest zero
  input  wire  [2:0]  s_axis_tuser_i,   // [2:0] cmd
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [0] acked, [1] tx_valid, [9:2] tx_byte,
                                        // [10] watchdog_reset_request,
                                        // [11] system_reset_request, [12] listening
);
  import i2ctcb_pkg::*;

  state_e state_q, state_d;

  // captured event
  logic [2:0] cmd_q;
  logic [7:0] data_q;
  logic       fault_q;

  // architectural state outside the stores
  logic [AW-1:0]          rcnt_q, rcnt_d;
  logic [IW-1:0]          ridx_q, ridx_d;
  logic                   listen_q, listen_d;
  logic [BUFFER_SIZE-1:0] rx_vld_q, rx_vld_d;
  logic [BUFFER_SIZE-1:0] rp_vld_q, rp_vld_d;

  logic [7:0] b0_q;

  // output register
  logic    out_vld_q, out_vld_d;
  result_t out_q, res;

  // store ports
  logic          rx_we, rx_re, rp_we, rp_re;
  logic [AW-1:0] rx_waddr, rx_raddr;
  logic [7:0]    rx_wdata, rp_wdata, rx_rdata, rp_rdata;
  logic [7:0]    b0, b1, rp_byte;
  logic [IW-1:0] rd_idx;
  logic          rd_in_range;
  logic          commit;

  i2ctcb_ram #(.WIDTH(8), .DEPTH(BUFFER_SIZE)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_waddr),
    .wdata_i (rx_wdata),
    .re_i    (rx_re),
    .raddr_i (rx_raddr),
    .rdata_o (rx_rdata)
  );

  i2ctcb_ram #(.WIDTH(8), .DEPTH(BUFFER_SIZE)) u_reply_ram (
    .clk_i   (clk_i),
    .we_i    (rp_we),
    .waddr_i ('0),
    .wdata_i (rp_wdata),
    .re_i    (rp_re),
    .raddr_i (rd_idx[AW-1:0]),
    .rdata_o (rp_rdata)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {3'b000, out_q.listening, out_q.system_reset_request,
                            out_q.watchdog_reset_request, out_q.tx_byte,
                            out_q.tx_valid, out_q.acked};

  // reply pointer for this event: a read address restarts at byte 0
  assign rd_idx      = (cmd_q == CMD_ADDR_READ) ? '0 : ridx_q;
  assign rd_in_range = (rd_idx < REPLY_END);

  // receive bytes as the parser sees them: unwritten or uncounted read as 0
  assign b0 = (rx_vld_q[0] && (rcnt_q != '0)) ? b0_q : 8'h00;
  assign b1 = (rx_vld_q[1] && (rcnt_q > AW'(1))) ? rx_rdata : 8'h00;
  assign rp_byte = (rd_in_range && rp_vld_q[rd_idx[AW-1:0]]) ? rp_rdata : 8'h00;

  // read side of the sequence
  always_comb begin
    rx_re    = (state_q == ST_RD0) || (state_q == ST_RD1);
    rx_raddr = (state_q == ST_RD1) ? AW'(1) : '0;
    rp_re    = (state_q == ST_RD0);
  end

  // result and state update, applied on commit in ST_FIN
  always_comb begin
    state_d   = state_q;
    commit    = 1'b0;
    rcnt_d    = rcnt_q;
    ridx_d    = ridx_q;
    listen_d  = listen_q;
    rx_vld_d  = rx_vld_q;
    rp_vld_d  = rp_vld_q;
    out_vld_d = out_vld_q & ~m_axis_tready_i;
    rx_we     = 1'b0;
    rx_waddr  = rcnt_q;
    rx_wdata  = data_q;
    rp_we     = 1'b0;
    rp_wdata  = (b0 == OP_REPLY) ? REPLY_BYTE : 8'h00;
    res       = '0;

    if (cmd_q == CMD_TICK) begin
      if (fault_q) begin
        listen_d = 1'b1;
      end else if (!listen_q) begin
        // parse: flags out, reply refilled, receive store emptied
        res.watchdog_reset_request = (b0 == OP_WDOG_B0) && (b1 == OP_WDOG_B1);
        res.system_reset_request   = (b0 == OP_SYS_RESET);
        rp_we       = 1'b1;
        rp_vld_d    = '0;
        rp_vld_d[0] = 1'b1;
        rx_vld_d    = '0;
        listen_d    = 1'b1;
      end
    end else if (listen_q && (cmd_q <= CMD_DATA_NACK)) begin
      res.acked = 1'b1;
      unique case (cmd_q)
        CMD_ADDR_WRITE: rcnt_d = '0;
        CMD_DATA_BYTE: begin
          if (rcnt_q < RX_LIMIT) begin
            rx_we            = 1'b1;
            rx_vld_d[rcnt_q] = 1'b1;
            rcnt_d           = rcnt_q + AW'(1);
          end
        end
        CMD_STOP: listen_d = 1'b0;
        CMD_ADDR_READ, CMD_DATA_ACK: begin
          res.tx_valid = 1'b1;
          res.tx_byte  = rp_byte;
          ridx_d       = rd_in_range ? rd_idx + IW'(1) : rd_idx;
        end
        default: ;
      endcase
    end
    res.listening = listen_d;

    unique case (state_q)
      ST_IDLE: if (s_axis_tvalid_i) state_d = ST_RD0;
      ST_RD0:  state_d = ST_RD1;
      ST_RD1:  state_d = ST_FIN;
      ST_FIN: begin
        if (!out_vld_q || m_axis_tready_i) begin
          commit    = 1'b1;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // nothing reaches the stores or state unless the event commits
    if (!commit) begin
      rx_we    = 1'b0;
      rp_we    = 1'b0;
      rcnt_d   = rcnt_q;
      ridx_d   = ridx_q;
      listen_d = listen_q;
      rx_vld_d = rx_vld_q;
      rp_vld_d = rp_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rcnt_q    <= '0;
      ridx_q    <= '0;
      listen_q  <= 1'b1;
      rx_vld_q  <= '0;
      rp_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rcnt_q    <= rcnt_d;
      ridx_q    <= ridx_d;
      listen_q  <= listen_d;
      rx_vld_q  <= rx_vld_d;
      rp_vld_q  <= rp_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      cmd_q   <= s_axis_tuser_i;
      data_q  <= s_axis_tdata_i[7:0];
      fault_q <= s_axis_tdata_i[8];
    end
    if (state_q == ST_RD1) begin
      b0_q <= rx_rdata;
    end
    if (commit) begin
      out_q <= res;
    end
  end

endmodule
`default_nettype wire
